@@ hdl/tcw_pkg.sv @@
// ============================================================================
// tcw_pkg
// Shared constants, types and helpers of the text console writer.
// ============================================================================
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS      = 80;
    localparam int SCREEN_CELLS = 2000;

    localparam int BYTE_W     = 8;
    localparam int CELL_W     = 16;
    localparam int CELL_IDX_W = 11;
    localparam int CNT_W      = CELL_IDX_W + 1;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int OPC_W      = 2;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [OPC_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR    = 2'd1;

    localparam logic [BYTE_W-1:0] DEFAULT_COLOR_RST = 8'd7;
    localparam logic [BYTE_W-1:0] BLANK_ATTR_RST    = 8'd15;

    localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'd9;
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;

    // cursor and column after a scroll: start of the last row
    localparam logic [CELL_IDX_W-1:0] SCROLL_CURSOR = CELL_IDX_W'(SCREEN_CELLS - COLUMNS);
    localparam logic [COL_W-1:0]      SCROLL_COL    =
        COL_W'((SCREEN_CELLS - COLUMNS) % COLUMNS);

    typedef struct packed {
        logic                  we;
        logic [CELL_IDX_W-1:0] waddr;
        logic [CELL_W-1:0]     wdata;
        logic [CELL_IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [BYTE_W-1:0] default_color;
        logic [BYTE_W-1:0] blank_attr;
    } t_cfg;

    typedef struct packed {
        logic [CELL_IDX_W-1:0] cursor_pos;
        logic [CELL_W-1:0]     cell_value;
        logic                  scrolled;
    } t_result;

    function automatic logic [CELL_W-1:0] blank_cell(input logic [BYTE_W-1:0] attr);
        return {attr, CH_SPACE};
    endfunction

endpackage

`default_nettype wire

@@ hdl/tcw_if.sv @@
// ============================================================================
// tcw_if
// Valid/ready channels of the text console writer: items in, results out,
// and register writes.
// ============================================================================
`default_nettype none

interface tcw_in_if;
    logic                              valid;
    logic                              ready;
    logic [tcw_pkg::OPC_W-1:0]         opcode;
    logic [tcw_pkg::BYTE_W-1:0]        char_code;
    logic [tcw_pkg::BYTE_W-1:0]        char_color;
    logic [tcw_pkg::CELL_IDX_W-1:0]    read_index;

    modport source (output valid, opcode, char_code, char_color, read_index, input ready);
    modport sink   (input valid, opcode, char_code, char_color, read_index, output ready);
endinterface

interface tcw_out_if;
    logic                              valid;
    logic                              ready;
    logic [tcw_pkg::CELL_IDX_W-1:0]    cursor_pos;
    logic [tcw_pkg::CELL_W-1:0]        cell_value;
    logic                              scrolled;

    modport source (output valid, cursor_pos, cell_value, scrolled, input ready);
    modport sink   (input valid, cursor_pos, cell_value, scrolled, output ready);
endinterface

interface tcw_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tcw_pkg::CFG_IDX_W-1:0]     index;
    logic [tcw_pkg::BYTE_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/tcw_ram.sv @@
// ============================================================================
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ============================================================================
`default_nettype none

module tcw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/tcw_ctrl.sv @@
// ============================================================================
// tcw_ctrl
// Sequencer of the console: cursor, character handling, scroll copy,
// clear sweep and cell read, all through the screen RAM ports.
// ============================================================================
`default_nettype none

module tcw_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    tcw_in_if.sink                             i_in,
    input  wire tcw_pkg::t_cfg                 i_cfg,
    output tcw_pkg::t_ram_req                  o_ram,
    input  wire logic [tcw_pkg::CELL_W-1:0]    i_rdata,
    output logic                               o_res_valid,
    output tcw_pkg::t_result                   o_res,
    input  wire logic                          i_res_take
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHAR,
        S_SCROLL,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } t_state;

    t_state                             r_state, n_state;
    logic                               r_init, n_init;
    logic [tcw_pkg::CELL_IDX_W-1:0]     r_cursor, n_cursor;
    logic [tcw_pkg::COL_W-1:0]          r_col, n_col;
    logic [tcw_pkg::CNT_W-1:0]          r_src, n_src;
    logic [1:0]                         r_rem, n_rem;
    logic [tcw_pkg::BYTE_W-1:0]         r_ch, n_ch;
    logic [tcw_pkg::BYTE_W-1:0]         r_color, n_color;
    logic [tcw_pkg::CELL_IDX_W-1:0]     r_ridx, n_ridx;
    logic [tcw_pkg::CELL_W-1:0]         r_cell, n_cell;
    logic                               r_scrolled, n_scrolled;
    logic                               r_wvld, n_wvld;
    logic [tcw_pkg::CELL_IDX_W-1:0]     r_wdst, n_wdst;
    logic                               r_wblank, n_wblank;

    logic                               accept;
    logic [tcw_pkg::CNT_W-1:0]          cur_sum;
    logic [tcw_pkg::COL_W-1:0]          col_nx;
    logic [tcw_pkg::CNT_W-1:0]          dst_full;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign dst_full   = r_src - tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);

    always_comb begin
        n_state    = r_state;
        n_init     = r_init;
        n_cursor   = r_cursor;
        n_col      = r_col;
        n_src      = r_src;
        n_rem      = r_rem;
        n_ch       = r_ch;
        n_color    = r_color;
        n_ridx     = r_ridx;
        n_cell     = r_cell;
        n_scrolled = r_scrolled;
        n_wvld     = 1'b0;
        n_wdst     = r_wdst;
        n_wblank   = r_wblank;
        cur_sum    = {1'b0, r_cursor};
        col_nx     = r_col;

        o_ram.we    = 1'b0;
        o_ram.waddr = r_wdst;
        o_ram.wdata = r_wblank ? tcw_pkg::blank_cell(i_cfg.blank_attr) : i_rdata;
        o_ram.raddr = r_ridx;

        unique case (r_state)
            S_CLEAR: begin
                // reset sweep uses the reset attribute, clear uses the register
                o_ram.we    = 1'b1;
                o_ram.waddr = r_src[tcw_pkg::CELL_IDX_W-1:0];
                o_ram.wdata = tcw_pkg::blank_cell(r_init ? tcw_pkg::BLANK_ATTR_RST
                                                         : i_cfg.blank_attr);
                if (r_src == tcw_pkg::CNT_W'(tcw_pkg::SCREEN_CELLS - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end else begin
                    n_src = r_src + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cell     = '0;
                    n_scrolled = 1'b0;
                    n_ridx     = i_in.read_index;
                    unique case (i_in.opcode)
                        tcw_pkg::OP_PUT: begin
                            if (i_in.char_code == tcw_pkg::CH_TAB) begin
                                n_ch    = tcw_pkg::CH_SPACE;
                                n_color = i_cfg.default_color;
                                n_rem   = 2'd3;
                            end else begin
                                n_ch    = i_in.char_code;
                                n_color = i_in.char_color;
                                n_rem   = 2'd0;
                            end
                            n_state = S_CHAR;
                        end
                        tcw_pkg::OP_READ: begin
                            n_state = (i_in.read_index <
                                       tcw_pkg::CELL_IDX_W'(tcw_pkg::SCREEN_CELLS))
                                      ? S_READ : S_DONE;
                        end
                        tcw_pkg::OP_CLEAR: begin
                            n_cursor = '0;
                            n_col    = '0;
                            n_src    = '0;
                            n_state  = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CHAR: begin
                unique case (r_ch)
                    tcw_pkg::CH_NEWLINE: begin
                        cur_sum = {1'b0, r_cursor} - tcw_pkg::CNT_W'(r_col)
                                  + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
                        col_nx  = '0;
                    end
                    tcw_pkg::CH_RETURN: begin
                        cur_sum = {1'b0, r_cursor} - tcw_pkg::CNT_W'(r_col);
                        col_nx  = '0;
                    end
                    tcw_pkg::CH_BACKSPACE: begin
                        if (r_col != '0) begin
                            cur_sum = {1'b0, r_cursor} - 1'b1;
                            col_nx  = r_col - 1'b1;
                        end
                    end
                    default: begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_cursor;
                        o_ram.wdata = {r_color, r_ch};
                        cur_sum     = {1'b0, r_cursor} + 1'b1;
                        col_nx      = (r_col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1))
                                      ? '0 : r_col + 1'b1;
                    end
                endcase
                if (cur_sum >= tcw_pkg::CNT_W'(tcw_pkg::SCREEN_CELLS)) begin
                    n_cursor   = tcw_pkg::SCROLL_CURSOR;
                    n_col      = tcw_pkg::SCROLL_COL;
                    n_scrolled = 1'b1;
                    n_src      = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
                    n_state    = S_SCROLL;
                end else begin
                    n_cursor = cur_sum[tcw_pkg::CELL_IDX_W-1:0];
                    n_col    = col_nx;
                    if (r_rem != 2'd0) begin
                        n_rem = r_rem - 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCROLL: begin
                // read at src, write one row up in the next cycle; past the
                // screen end the write stage fills the bottom row with blanks
                o_ram.we = r_wvld;
                if (r_src < tcw_pkg::CNT_W'(tcw_pkg::SCREEN_CELLS + tcw_pkg::COLUMNS)) begin
                    o_ram.raddr = (r_src < tcw_pkg::CNT_W'(tcw_pkg::SCREEN_CELLS))
                                  ? r_src[tcw_pkg::CELL_IDX_W-1:0] : '0;
                    n_wvld   = 1'b1;
                    n_wdst   = dst_full[tcw_pkg::CELL_IDX_W-1:0];
                    n_wblank = (r_src >= tcw_pkg::CNT_W'(tcw_pkg::SCREEN_CELLS));
                    n_src    = r_src + 1'b1;
                end else if (r_rem != 2'd0) begin
                    n_rem   = r_rem - 1'b1;
                    n_state = S_CHAR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_ram.raddr = r_ridx;
                n_state     = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                n_cell  = i_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_init     <= 1'b1;
            r_cursor   <= '0;
            r_col      <= '0;
            r_src      <= '0;
            r_rem      <= '0;
            r_wvld     <= 1'b0;
            r_scrolled <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init     <= n_init;
            r_cursor   <= n_cursor;
            r_col      <= n_col;
            r_src      <= n_src;
            r_rem      <= n_rem;
            r_wvld     <= n_wvld;
            r_scrolled <= n_scrolled;
        end
        r_ch     <= n_ch;
        r_color  <= n_color;
        r_ridx   <= n_ridx;
        r_cell   <= n_cell;
        r_wdst   <= n_wdst;
        r_wblank <= n_wblank;
    end

    assign o_res_valid      = (r_state == S_DONE);
    assign o_res.cursor_pos = r_cursor;
    assign o_res.cell_value = r_cell;
    assign o_res.scrolled   = r_scrolled;

    a_waddr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (o_ram.waddr < tcw_pkg::CELL_IDX_W'(tcw_pkg::SCREEN_CELLS)))
        else $error("screen write beyond last cell");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            (r_cursor < tcw_pkg::CELL_IDX_W'(tcw_pkg::SCREEN_CELLS)) &&
            (r_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)))
        else $error("cursor or column out of range when idle");

    a_scroll_homes_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL) |-> (r_cursor == tcw_pkg::SCROLL_CURSOR) && r_scrolled)
        else $error("scroll without cursor at last row start");

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !i_in.ready)
        else $error("item accepted during reset clear");

endmodule

`default_nettype wire

@@ hdl/text_console_writer_core.sv @@
// ============================================================================
// text_console_writer_core
// Character-cell text console with a screen RAM and a cursor.
// ============================================================================
// After reset the block blanks all SCREEN_CELLS (2000) cells of the screen RAM
// and takes no item meanwhile; register writes are taken at any time. A scroll
// moves the screen up one row, as the RAM copies one cell per cycle through its
// single write port, and a clear blanks every cell. A finished result sits in
// an output register, so the next item is taken while it waits.
`default_nettype none

module text_console_writer_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcw_in_if.sink    i_in,
    tcw_out_if.source o_out,
    tcw_cfg_if.sink   i_cfg
);

    tcw_pkg::t_cfg                  r_cfg;
    tcw_pkg::t_ram_req              ram_req;
    logic [tcw_pkg::CELL_W-1:0]     ram_rdata;
    logic                           res_valid;
    tcw_pkg::t_result               res;
    logic                           res_take;
    logic                           r_out_valid;
    tcw_pkg::t_result               r_out;

    // registers are always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_color <= tcw_pkg::DEFAULT_COLOR_RST;
            r_cfg.blank_attr    <= tcw_pkg::BLANK_ATTR_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tcw_pkg::REG_DEFAULT_COLOR: r_cfg.default_color <= i_cfg.data;
                tcw_pkg::REG_BLANK_ATTR:    r_cfg.blank_attr    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    tcw_ram #(
        .WIDTH  (tcw_pkg::CELL_W),
        .DEPTH  (tcw_pkg::SCREEN_CELLS),
        .ADDR_W (tcw_pkg::CELL_IDX_W)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    assign res_take = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.cursor_pos = r_out.cursor_pos;
    assign o_out.cell_value = r_out.cell_value;
    assign o_out.scrolled   = r_out.scrolled;

endmodule

`default_nettype wire
